// ===== rtl/core/cbq_pkg.sv =====
`default_nettype none

package cbq_pkg;

  // Field and datapath widths
  localparam int unsigned SampleW   = 16;
  localparam int unsigned CoefW     = 20;
  localparam int unsigned StateW    = 32;
  localparam int unsigned ProdW     = CoefW + StateW;
  localparam int unsigned AccW      = 56;
  localparam int unsigned FracShift = 18;
  localparam int unsigned RndW      = AccW - FracShift;

  // Configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 60;
  localparam int unsigned FfW      = 3 * CoefW;
  localparam int unsigned FbW      = 2 * CoefW;
  localparam int unsigned MaxStages = 2;

  localparam logic [CfgIdxW-1:0] CFG_FF1     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FB1     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_FF2     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_FB2     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_OUT_MIN = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_OUT_MAX = 3'd5;

  localparam logic signed [SampleW-1:0] OutMinRst = -16'sd20480;
  localparam logic signed [SampleW-1:0] OutMaxRst = 16'sd20480;

  // Slots of one section's history in the state memory
  localparam logic [1:0] SLOT_X1 = 2'd0;
  localparam logic [1:0] SLOT_X2 = 2'd1;
  localparam logic [1:0] SLOT_Y1 = 2'd2;
  localparam logic [1:0] SLOT_Y2 = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/core/cbq_stream_if.sv =====
`default_nettype none

interface cbq_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [cbq_pkg::SampleW-1:0]  sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface cbq_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [cbq_pkg::SampleW-1:0]  sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cascaded_biquad_iir_filter_unit.sv =====
`default_nettype none

// Channel   Direction  Payload                 Handshake
// in_i      sink       sample_in  s16 Q5.11    valid/ready
// out_o     source     sample_out s16 Q5.11    valid/ready
// cfg       write      cfg_idx_i, cfg_data_i   cfg_we_i, no back-pressure
//
// A single multiply-accumulate unit walks the five taps of each biquad section in turn.
// The input is taken only in the idle state, so a new item is taken only after the
// previous one has left the last section.
// Reset clears the section history (via per-entry valid bits) and resets all but the datapath registers.
// A full output register stalls the final cycle of an item until it is taken.

module cascaded_biquad_iir_filter_unit #(
  parameter int unsigned NumStages = 2
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  cbq_in_if.sink                           in_i,
  cbq_out_if.source                        out_o,
  input  wire                              cfg_we_i,
  input  wire  [cbq_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire  [cbq_pkg::CfgDataW-1:0]     cfg_data_i
);

  // The state memory holds four history words per section.
  localparam int unsigned Depth = NumStages * 4;
  localparam int unsigned AddrW = $clog2(Depth);

  // Steps within one section. Reads of the history run in steps 0 to 3,
  // products are formed in steps 0 to 4 and summed in the step after.
  localparam logic [2:0] StepFirst  = 3'd0;
  localparam logic [2:0] StepX1Wr   = 3'd1;
  localparam logic [2:0] StepX2Wr   = 3'd2;
  localparam logic [2:0] StepRdLast = 3'd3;
  localparam logic [2:0] StepY2Wr   = 3'd4;
  localparam logic [2:0] StepRound  = 3'd6;
  localparam logic [2:0] StepLast   = 3'd7;
  localparam logic [2:0] StepFbFirst = 3'd3;
  localparam logic [2:0] StepMacLast = 3'd4;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e state_q;
  logic [2:0] step_q;
  logic       sec_q;
  logic       out_valid_q;
  logic signed [cbq_pkg::SampleW-1:0] out_data_q;
  logic [Depth-1:0] ent_vld_q;
  logic       rvld_q;

  // Configuration registers
  logic [cbq_pkg::FfW-1:0] ff_q [cbq_pkg::MaxStages];
  logic [cbq_pkg::FbW-1:0] fb_q [cbq_pkg::MaxStages];
  logic signed [cbq_pkg::SampleW-1:0] out_min_q;
  logic signed [cbq_pkg::SampleW-1:0] out_max_q;

  // Datapath registers
  logic signed [cbq_pkg::StateW-1:0] x_q;
  logic signed [cbq_pkg::StateW-1:0] x1c_q;
  logic signed [cbq_pkg::StateW-1:0] y1c_q;
  logic signed [cbq_pkg::StateW-1:0] rdata_q;
  logic signed [cbq_pkg::ProdW-1:0]  prod_q;
  logic                              psub_q;
  logic                              pvld_q;
  logic signed [cbq_pkg::AccW-1:0]   acc_q;
  logic signed [cbq_pkg::RndW-1:0]   rnd_q;

  logic signed [cbq_pkg::StateW-1:0] mem_q [Depth];

  logic in_acc;
  logic last_sec;
  logic stall;
  logic finish;
  logic rd_en;
  logic [AddrW-1:0] raddr;
  logic mem_we;
  logic [AddrW-1:0] waddr;
  logic signed [cbq_pkg::StateW-1:0] wdata;
  logic signed [cbq_pkg::StateW-1:0] rd_val;
  logic signed [cbq_pkg::StateW-1:0] op;
  logic signed [cbq_pkg::CoefW-1:0]  coef;
  logic signed [cbq_pkg::ProdW-1:0]  prod_d;
  logic signed [cbq_pkg::AccW-1:0]   acc_d;
  logic signed [cbq_pkg::AccW-1:0]   rsum;
  logic signed [cbq_pkg::StateW-1:0] sat;
  logic signed [cbq_pkg::StateW-1:0] y_d;
  logic signed [cbq_pkg::StateW-1:0] min_ext;
  logic signed [cbq_pkg::StateW-1:0] max_ext;
  logic fits;

  assign in_i.ready       = (state_q == ST_IDLE);
  assign in_acc           = in_i.valid && in_i.ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_data_q;

  assign last_sec = ({31'd0, sec_q} == NumStages - 1);
  // The last step of the last section waits while the previous result is still held.
  assign stall  = (state_q == ST_RUN) && (step_q == StepLast) && last_sec &&
                  out_valid_q && !out_o.ready;
  assign finish = (state_q == ST_RUN) && (step_q == StepLast) && !stall;

  // History reads: step n reads slot n, the data arrives in the next step.
  assign rd_en = (state_q == ST_RUN) && (step_q <= StepRdLast);
  assign raddr = AddrW'({sec_q, step_q[1:0]});
  assign rd_val = rvld_q ? rdata_q : '0;

  // History writes are spaced so that each slot is read before it is overwritten.
  always_comb begin
    mem_we = 1'b0;
    waddr  = AddrW'({sec_q, cbq_pkg::SLOT_X1});
    wdata  = x_q;
    if (state_q == ST_RUN) begin
      unique case (step_q)
        StepX1Wr: begin
          mem_we = 1'b1;
          waddr  = AddrW'({sec_q, cbq_pkg::SLOT_X1});
          wdata  = x_q;
        end
        StepX2Wr: begin
          mem_we = 1'b1;
          waddr  = AddrW'({sec_q, cbq_pkg::SLOT_X2});
          wdata  = x1c_q;
        end
        StepY2Wr: begin
          mem_we = 1'b1;
          waddr  = AddrW'({sec_q, cbq_pkg::SLOT_Y2});
          wdata  = y1c_q;
        end
        StepLast: begin
          mem_we = !stall;
          waddr  = AddrW'({sec_q, cbq_pkg::SLOT_Y1});
          wdata  = y_d;
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  // Coefficient for the tap formed in this step.
  always_comb begin
    case (step_q)
      3'd0:    coef = ff_q[sec_q][cbq_pkg::CoefW-1:0];
      3'd1:    coef = ff_q[sec_q][2*cbq_pkg::CoefW-1:cbq_pkg::CoefW];
      3'd2:    coef = ff_q[sec_q][3*cbq_pkg::CoefW-1:2*cbq_pkg::CoefW];
      3'd3:    coef = fb_q[sec_q][cbq_pkg::CoefW-1:0];
      3'd4:    coef = fb_q[sec_q][2*cbq_pkg::CoefW-1:cbq_pkg::CoefW];
      default: coef = '0;
    endcase
  end

  assign op     = (step_q == StepFirst) ? x_q : rd_val;
  assign prod_d = coef * op;
  assign acc_d  = psub_q ? acc_q - cbq_pkg::AccW'(prod_q) : acc_q + cbq_pkg::AccW'(prod_q);

  // Round half up at the Q.11 point, floor through the arithmetic shift.
  assign rsum = acc_q + cbq_pkg::AccW'(1 << (cbq_pkg::FracShift - 1));

  // Saturate the rounded sum to 32 bits, then clamp the final section only.
  assign fits = (rnd_q[cbq_pkg::RndW-1:cbq_pkg::StateW-1] == '0) ||
                (rnd_q[cbq_pkg::RndW-1:cbq_pkg::StateW-1] == '1);
  assign min_ext = cbq_pkg::StateW'(out_min_q);
  assign max_ext = cbq_pkg::StateW'(out_max_q);

  always_comb begin
    if (fits) begin
      sat = rnd_q[cbq_pkg::StateW-1:0];
    end else if (rnd_q[cbq_pkg::RndW-1]) begin
      sat = {1'b1, {(cbq_pkg::StateW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(cbq_pkg::StateW-1){1'b1}}};
    end
    y_d = sat;
    if (last_sec) begin
      if (sat < min_ext) begin
        y_d = min_ext;
      end else if (sat > max_ext) begin
        y_d = max_ext;
      end
    end
  end

  // Sequencer, registers and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= StepFirst;
      sec_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      ent_vld_q   <= '0;
      rvld_q      <= 1'b0;
      pvld_q      <= 1'b0;
      for (int i = 0; i < cbq_pkg::MaxStages; i++) begin
        ff_q[i] <= '0;
        fb_q[i] <= '0;
      end
      out_min_q <= cbq_pkg::OutMinRst;
      out_max_q <= cbq_pkg::OutMaxRst;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          cbq_pkg::CFG_FF1:     ff_q[0] <= cfg_data_i[cbq_pkg::FfW-1:0];
          cbq_pkg::CFG_FB1:     fb_q[0] <= cfg_data_i[cbq_pkg::FbW-1:0];
          cbq_pkg::CFG_FF2:     ff_q[1] <= cfg_data_i[cbq_pkg::FfW-1:0];
          cbq_pkg::CFG_FB2:     fb_q[1] <= cfg_data_i[cbq_pkg::FbW-1:0];
          cbq_pkg::CFG_OUT_MIN: out_min_q <= cfg_data_i[cbq_pkg::SampleW-1:0];
          cbq_pkg::CFG_OUT_MAX: out_max_q <= cfg_data_i[cbq_pkg::SampleW-1:0];
          default: ;
        endcase
      end

      if (rd_en) begin
        rvld_q <= ent_vld_q[raddr];
      end
      if (mem_we) begin
        ent_vld_q[waddr] <= 1'b1;
      end
      pvld_q <= (state_q == ST_RUN) && (step_q <= StepMacLast);

      // A result taken in the cycle that a new one is produced is simply replaced.
      if (out_valid_q && out_o.ready && !(finish && last_sec)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_RUN;
            step_q  <= StepFirst;
            sec_q   <= 1'b0;
          end
        end
        ST_RUN: begin
          if (finish) begin
            step_q <= StepFirst;
            if (last_sec) begin
              state_q     <= ST_IDLE;
              out_valid_q <= 1'b1;
              out_data_q  <= y_d[cbq_pkg::SampleW-1:0];
            end else begin
              sec_q <= 1'b1;
            end
          end else if (!stall) begin
            step_q <= step_q + 3'd1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers carry payload only.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= cbq_pkg::StateW'(in_i.sample_in);
    end else if (finish) begin
      // The section output is the next section's input.
      x_q <= y_d;
    end
    if (step_q == StepX1Wr) begin
      x1c_q <= rd_val;
    end
    if (step_q == StepRdLast) begin
      y1c_q <= rd_val;
    end
    prod_q <= prod_d;
    psub_q <= (step_q >= StepFbFirst);
    if (step_q == StepFirst) begin
      acc_q <= '0;
    end else if (pvld_q) begin
      acc_q <= acc_d;
    end
    if (step_q == StepRound) begin
      rnd_q <= cbq_pkg::RndW'(rsum >>> cbq_pkg::FracShift);
    end
  end

  // State memory: one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cbq_checker.sv =====
`default_nettype none

module cbq_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire in_valid_i,
  input wire in_ready_i,
  input wire out_valid_i,
  input wire out_ready_i,
  input wire [cbq_pkg::SampleW-1:0] out_data_i
);

  // A held result stays until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // Only one item is in the filter at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item taken while busy");

  // Ready only drops because an item was taken.
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(in_valid_i))
    else $error("ready dropped without an item");

  // A result never appears straight after an item is taken.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_valid_i && in_ready_i, 1) &&
                           !$past(in_valid_i && in_ready_i, 2))
    else $error("result too early");

endmodule

bind cascaded_biquad_iir_filter_unit cbq_checker u_cbq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.sample_out)
);

`default_nettype wire

// ===== verif/testbench.sv =====
typedef logic signed [cbq_pkg::SampleW-1:0] sample_t;

// Bit-exact tracker of the two-section biquad cascade. It holds its own copy of the
// coefficient and clamp registers and of every section's history, and queues the
// output sample that each accepted input sample must produce.
class biquad_cascade_model;
  int sections;
  logic [cbq_pkg::FfW-1:0] ff [2];
  logic [cbq_pkg::FbW-1:0] fb [2];
  sample_t out_lo;
  sample_t out_hi;
  logic signed [cbq_pkg::StateW-1:0] x1 [2];
  logic signed [cbq_pkg::StateW-1:0] x2 [2];
  logic signed [cbq_pkg::StateW-1:0] y1 [2];
  logic signed [cbq_pkg::StateW-1:0] y2 [2];
  sample_t expected_outputs [$];
  int taken;
  int checked;
  int clamped;
  int failures;

  function new(int n);
    int k;
    sections = n;
    for (k = 0; k < 2; k++) begin
      ff[k] = '0;
      fb[k] = '0;
      x1[k] = '0;
      x2[k] = '0;
      y1[k] = '0;
      y2[k] = '0;
    end
    out_lo = cbq_pkg::OutMinRst;
    out_hi = cbq_pkg::OutMaxRst;
    taken = 0;
    checked = 0;
    clamped = 0;
    failures = 0;
  endfunction

  // Registers are only ever written while the filter is idle, so the copy here
  // always matches what the hardware applies to the next sample.
  function void set_register(logic [cbq_pkg::CfgIdxW-1:0] idx,
                             logic [cbq_pkg::CfgDataW-1:0] data);
    case (idx)
      cbq_pkg::CFG_FF1:     ff[0] = data[cbq_pkg::FfW-1:0];
      cbq_pkg::CFG_FB1:     fb[0] = data[cbq_pkg::FbW-1:0];
      cbq_pkg::CFG_FF2:     ff[1] = data[cbq_pkg::FfW-1:0];
      cbq_pkg::CFG_FB2:     fb[1] = data[cbq_pkg::FbW-1:0];
      cbq_pkg::CFG_OUT_MIN: out_lo = data[cbq_pkg::SampleW-1:0];
      cbq_pkg::CFG_OUT_MAX: out_hi = data[cbq_pkg::SampleW-1:0];
      default: ;
    endcase
  endfunction

  // One Q2.18 coefficient, sign-extended, from a packed register.
  function longint tap(logic [cbq_pkg::CfgDataW-1:0] word, int slot);
    logic signed [cbq_pkg::CoefW-1:0] c;
    c = word[slot*cbq_pkg::CoefW +: cbq_pkg::CoefW];
    return longint'(c);
  endfunction

  // Round half towards plus infinity back to Q.11, then saturate to 32 bits.
  function logic signed [31:0] requantise(longint acc);
    longint q;
    q = (acc + (64'sd1 <<< (cbq_pkg::FracShift - 1))) >>> cbq_pkg::FracShift;
    if (q > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (q < -64'sd2147483648) return 32'sh8000_0000;
    return q[31:0];
  endfunction

  function void take_sample(sample_t s);
    logic signed [31:0] x;
    logic signed [31:0] y;
    longint acc;
    int k;
    y = cbq_pkg::StateW'(s);
    for (k = 0; k < sections; k++) begin
      x = y;
      acc = tap(ff[k], 0) * longint'(x) + tap(ff[k], 1) * longint'(x1[k])
          + tap(ff[k], 2) * longint'(x2[k])
          - tap(cbq_pkg::CfgDataW'(fb[k]), 0) * longint'(y1[k])
          - tap(cbq_pkg::CfgDataW'(fb[k]), 1) * longint'(y2[k]);
      y = requantise(acc);
      // Only the last section is clamped, and the clamped value is its history.
      if (k == sections - 1) begin
        if (y < out_lo) begin
          y = out_lo;
          clamped++;
        end else if (y > out_hi) begin
          y = out_hi;
          clamped++;
        end
      end
      x2[k] = x1[k];
      x1[k] = x;
      y2[k] = y1[k];
      y1[k] = y;
    end
    expected_outputs.push_back(y[cbq_pkg::SampleW-1:0]);
    taken++;
  endfunction

  function void check_output(sample_t got);
    sample_t want;
    checked++;
    if (expected_outputs.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("Output item %0d (%0d) arrived with no sample awaiting it", checked, got);
      return;
    end
    want = expected_outputs.pop_front();
    if (got !== want) begin
      failures++;
      if (failures <= 10)
        $display("Output item %0d: expected %0d, got %0d", checked, want, got);
    end
  endfunction

  function int pending();
    return expected_outputs.size();
  endfunction
endclass

module testbench;

  localparam int unsigned NUM_SECTIONS = 2;
  // The register index is three bits wide, so two indexes address nothing.
  localparam logic [cbq_pkg::CfgIdxW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [cbq_pkg::CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;
  localparam int Q_ONE = 1 << cbq_pkg::FracShift;
  localparam int COEF_MAX = 524287;
  localparam int COEF_MIN = -524288;
  // Settling time after a drain, with margin over one item through both sections.
  localparam int SETTLE = 24;
  localparam int BURST_LEN = 85;
  // The slowest correct run is 535 items; the limit sits far above what they need.
  localparam int CYCLE_LIMIT = 600000;

  logic                         clk;
  logic                         rst_ni;
  logic                         cfg_we;
  logic [cbq_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [cbq_pkg::CfgDataW-1:0] cfg_data;
  bit                           steady;
  int                           cycles;
  int                           settings;

  cbq_in_if  in_ch ();
  cbq_out_if out_ch ();

  biquad_cascade_model board;

  cascaded_biquad_iir_filter_unit #(
    .NumStages (NUM_SECTIONS)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a run that never drains ends here as a failure.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run stopped after %0d cycles without completing", cycles);
    $display("== FAIL ==");
    $finish;
  end

  // Output side: an item is taken at a rising edge where valid and ready are both
  // high. Ready is redrawn at every falling edge, held high during the steady phase.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) board.check_output(out_ch.sample_out);
      @(negedge clk);
      out_ch.ready <= steady || ($urandom_range(99) >= 25);
    end
  end

  // Packs three feedforward coefficients, b0 in the lowest slot.
  function automatic logic [cbq_pkg::CfgDataW-1:0] ff_word(int b0, int b1, int b2);
    return {b2[cbq_pkg::CoefW-1:0], b1[cbq_pkg::CoefW-1:0], b0[cbq_pkg::CoefW-1:0]};
  endfunction

  // Packs a1 and a2. The bits above the register are filled with noise, which
  // the block must drop.
  function automatic logic [cbq_pkg::CfgDataW-1:0] fb_word(int a1, int a2);
    logic [cbq_pkg::CfgDataW-1:0] w;
    w = cbq_pkg::CfgDataW'({$urandom, $urandom});
    w[cbq_pkg::CoefW-1:0] = a1[cbq_pkg::CoefW-1:0];
    w[2*cbq_pkg::CoefW-1:cbq_pkg::CoefW] = a2[cbq_pkg::CoefW-1:0];
    return w;
  endfunction

  // A clamp bound, again with noise above its sixteen bits.
  function automatic logic [cbq_pkg::CfgDataW-1:0] clamp_word(int v);
    logic [cbq_pkg::CfgDataW-1:0] w;
    w = cbq_pkg::CfgDataW'({$urandom, $urandom});
    w[cbq_pkg::SampleW-1:0] = v[cbq_pkg::SampleW-1:0];
    return w;
  endfunction

  function automatic logic [cbq_pkg::CfgDataW-1:0] random_word();
    return cbq_pkg::CfgDataW'({$urandom, $urandom});
  endfunction

  // Coefficients of at most an eighth in magnitude keep the cascade well behaved.
  function automatic int small_coef();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  function automatic int random_bound();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  // Mostly uniform samples, with the rails and small values near zero mixed in.
  function automatic sample_t random_sample();
    sample_t s;
    case ($urandom_range(9))
      0: s = 16'sh8000;
      1: s = 16'sh7FFF;
      2: s = cbq_pkg::SampleW'($urandom_range(511) - 256);
      default: s = cbq_pkg::SampleW'($urandom_range(65535));
    endcase
    return s;
  endfunction

  // Each write is held for one cycle; the caller lowers the enable after a batch.
  task automatic cfg_write(input logic [cbq_pkg::CfgIdxW-1:0] idx,
                           input logic [cbq_pkg::CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    board.set_register(idx, data);
    @(negedge clk);
  endtask

  // Writes every register, then both unused indexes with noise that must not land
  // anywhere.
  task automatic load_filter(input logic [cbq_pkg::CfgDataW-1:0] ff1,
                             input logic [cbq_pkg::CfgDataW-1:0] fb1,
                             input logic [cbq_pkg::CfgDataW-1:0] ff2,
                             input logic [cbq_pkg::CfgDataW-1:0] fb2,
                             input int lo, input int hi);
    cfg_write(cbq_pkg::CFG_FF1, ff1);
    cfg_write(cbq_pkg::CFG_FB1, fb1);
    cfg_write(cbq_pkg::CFG_FF2, ff2);
    cfg_write(cbq_pkg::CFG_FB2, fb2);
    cfg_write(cbq_pkg::CFG_OUT_MIN, clamp_word(lo));
    cfg_write(cbq_pkg::CFG_OUT_MAX, clamp_word(hi));
    cfg_write(CFG_SPARE_LO, random_word());
    cfg_write(CFG_SPARE_HI, random_word());
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Called at a falling edge and returns at one. Outside the steady phase random gaps
  // come first; then the item is held until the block takes it.
  task automatic send_sample(input sample_t s);
    while (!steady && $urandom_range(99) < 25) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample_in <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.take_sample(s);
    @(negedge clk);
  endtask

  // Holds the input back until every expected output has come, then lets the
  // block settle before anything else happens.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic run_burst(input int n, input bit pause_midway);
    int i;
    for (i = 0; i < n; i++) begin
      if ((pause_midway && i == n / 2) || $urandom_range(99) == 0) drain();
      send_sample(random_sample());
    end
  endtask

  initial begin
    int p;
    int i;
    int lo;
    int hi;
    int t;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.sample_in = '0;
    steady = 1'b0;
    settings = 0;
    board = new(NUM_SECTIONS);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    // Straight out of reset every coefficient is zero, so even the rails give zero.
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    drain();

    // Unity gain through both sections with the clamp bounds left at their reset
    // values: the rails are cut to plus and minus ten volts, small values pass.
    cfg_write(cbq_pkg::CFG_FF1, ff_word(Q_ONE, 0, 0));
    cfg_write(cbq_pkg::CFG_FB1, fb_word(0, 0));
    cfg_write(cbq_pkg::CFG_FF2, ff_word(Q_ONE, 0, 0));
    cfg_write(cbq_pkg::CFG_FB2, fb_word(0, 0));
    cfg_we <= 1'b0;
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    drain();

    // Extreme coefficients and the widest clamp range. The first section's output
    // runs well past sixteen bits and must reach the second section unclamped.
    load_filter(ff_word(COEF_MIN, 0, 0), fb_word(0, 0), ff_word(COEF_MAX, 0, 0),
                fb_word(0, 0), -32768, 32767);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(-16'sd1);
    drain();

    // Crossed bounds: anything below the lower bound takes it, anything else is
    // above the upper bound and takes that.
    load_filter(ff_word(Q_ONE, 0, 0), fb_word(0, 0), ff_word(Q_ONE, 0, 0), fb_word(0, 0),
                100, -100);
    send_sample(16'sd0);
    send_sample(16'sd100);
    send_sample(16'sd500);
    drain();

    // An unstable first section: feedback of minus two on both taps grows the
    // history by nearly three times per sample until it saturates at 32 bits.
    load_filter(ff_word(COEF_MAX, 0, 0), fb_word(COEF_MIN, COEF_MIN), ff_word(Q_ONE, 0, 0),
                fb_word(0, 0), -20480, 20480);
    for (i = 0; i < 13; i++) send_sample(16'sh7FFF);

    // Random phases, each under a fresh register setting.
    for (p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: begin
          // The stock section coefficients: a first-order high-pass followed by a
          // low-pass biquad.
          load_filter(ff_word(262141, -262141, 0), fb_word(-231151, 0),
                      ff_word(57, 115, 57), fb_word(-489528, 231264), -20480, 20480);
        end
        1: begin
          // Every coefficient bit at random and ordered random bounds, with no idling on either side.
          lo = random_bound();
          hi = random_bound();
          if (lo > hi) begin
            t = lo;
            lo = hi;
            hi = t;
          end
          load_filter(random_word(), random_word(), random_word(), random_word(), lo, hi);
          steady = 1'b1;
        end
        2: begin
          load_filter(ff_word(COEF_MAX, COEF_MAX, COEF_MAX), fb_word(COEF_MAX, COEF_MAX),
                      ff_word(COEF_MAX, COEF_MAX, COEF_MAX), fb_word(COEF_MAX, COEF_MAX),
                      -32768, 32767);
        end
        3: begin
          // Equal bounds pin every output to one value.
          lo = random_bound();
          load_filter(ff_word(COEF_MIN, COEF_MIN, COEF_MIN), fb_word(COEF_MIN, COEF_MIN),
                      ff_word(COEF_MIN, COEF_MIN, COEF_MIN), fb_word(COEF_MIN, COEF_MIN),
                      lo, lo);
        end
        4: begin
          load_filter(ff_word(small_coef(), small_coef(), small_coef()),
                      fb_word(small_coef(), small_coef()),
                      ff_word(small_coef(), small_coef(), small_coef()),
                      fb_word(small_coef(), small_coef()), random_bound(), random_bound());
        end
        5: begin
          lo = random_bound();
          hi = random_bound();
          if (lo <= hi) begin
            t = lo;
            lo = hi;
            hi = t;
          end
          load_filter(random_word(), random_word(), random_word(), random_word(), lo, hi);
        end
        default: ;
      endcase
      run_burst(BURST_LEN, p == 0);
      steady = 1'b0;
    end

    drain();
    $display("Filtered %0d samples under %0d register settings; %0d outputs hit a bound.",
             board.taken, settings, board.clamped);
    $display("Also covered reset values, crossed and equal bounds, 32-bit saturation %s",
             "and writes to unused indexes.");
    if (board.failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches in %0d output items", board.failures, board.checked);
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/cbq_pkg.sv
rtl/core/cbq_stream_if.sv
rtl/core/cascaded_biquad_iir_filter_unit.sv
rtl/core/cbq_checker.sv
verif/testbench.sv
